>>> src/polyline_length_accumulator_unit_macros.svh
// assertion helpers for the polyline length accumulator
`ifndef POLYLINE_LENGTH_ACCUMULATOR_UNIT_MACROS_SVH
`define POLYLINE_LENGTH_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PLA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pla_pkg.sv
`default_nettype none

package pla_pkg;

    // field widths
    localparam int COORD_W = 16;
    localparam int SUM_W   = 32;
    localparam int TOTAL_W = 32;

    // square root datapath sizes
    localparam int SQ_W   = 2 * COORD_W;
    localparam int ROOT_W = COORD_W + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [COORD_W-1:0]        t_mag;
    typedef logic [ROOT_W-1:0]         t_len;
    typedef logic [SUM_W-1:0]          t_sum;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      last_point;
    } t_in_item;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_length;
        logic               overflowed;
    } t_out_item;

    // segment length request and response
    typedef struct packed {
        logic start;
        t_mag mx;
        t_mag my;
    } t_seg_req;

    typedef struct packed {
        logic done;
        t_len len;
    } t_seg_rsp;

    // magnitude of the difference of two signed coordinates
    function automatic t_mag abs_diff(input t_coord a, input t_coord b);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/pla_seglen.sv
`default_nettype none

module pla_seglen
    import pla_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_seg_req i_req,
    output t_seg_rsp      o_rsp
);

    localparam int CNT_W = $clog2(ROOT_W);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SQR  = 4'b0010,
        S_SUM  = 4'b0100,
        S_ROOT = 4'b1000
    } t_seg_state;

    t_seg_state        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    t_mag              r_mx, r_my;
    logic [SQ_W-1:0]   r_addx, r_addy;
    logic [SQ_W-1:0]   r_sqx, r_sqy;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W:0]   r_rem;
    t_len              r_root;
    logic              r_done;
    t_len              r_len;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_diff;
    logic              take;
    logic [ROOT_W:0]   n_rem;
    t_len              n_root;

    // one root digit per cycle from the top bit pair of the radicand
    always_comb begin
        rem_sh   = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial    = {1'b0, r_root, 2'b01};
        rem_diff = rem_sh - trial;
        take     = (rem_sh >= trial);
        n_rem    = take ? rem_diff[ROOT_W:0] : rem_sh[ROOT_W:0];
        n_root   = {r_root[ROOT_W-2:0], take};
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) n_state = S_SQR;
            end
            S_SQR: begin
                if (r_cnt == '0) n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (r_cnt == '0) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_ROOT) && (r_cnt == '0);
        end
    end

    // datapath: shift-add squaring, then the digit-by-digit root
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mx   <= i_req.mx;
                r_my   <= i_req.my;
                r_addx <= SQ_W'(i_req.mx);
                r_addy <= SQ_W'(i_req.my);
                r_sqx  <= '0;
                r_sqy  <= '0;
                r_cnt  <= CNT_W'(COORD_W - 1);
            end
            S_SQR: begin
                if (r_mx[0]) r_sqx <= r_sqx + r_addx;
                if (r_my[0]) r_sqy <= r_sqy + r_addy;
                r_mx   <= r_mx >> 1;
                r_my   <= r_my >> 1;
                r_addx <= r_addx << 1;
                r_addy <= r_addy << 1;
                r_cnt  <= r_cnt - 1'b1;
            end
            S_SUM: begin
                r_rad  <= RAD_W'(r_sqx) + RAD_W'(r_sqy);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(ROOT_W - 1);
            end
            S_ROOT: begin
                r_rad  <= r_rad << 2;
                r_rem  <= n_rem;
                r_root <= n_root;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) r_len <= n_root;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.len  = r_len;

endmodule

`default_nettype wire

>>> src/polyline_length_accumulator_unit.sv
// Polyline length accumulator: vertices arrive one per request as signed Q8.8 (x, y) with a
// last-point flag; each vertex after the first adds floor(sqrt(dx^2 + dy^2)) to a saturating
// Q24.8 total, and closed mode also adds the segment from the last vertex back to the first.
// The total and an overflow flag go out on the last vertex, after which the path state clears.
// Every vertex after the first waits on the shared segment unit: bit-serial squaring, forming
// the radicand, then one root digit per step, plus handoff and accumulate. In closed mode the
// last vertex also waits for the closing segment on the same unit. The output register lets
// the next vertex be taken while a total waits to be read. Config writes are always accepted.
`default_nettype none

module polyline_length_accumulator_unit
    import pla_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_data
);

`include "polyline_length_accumulator_unit_macros.svh"

    typedef enum logic [4:0] {
        T_IDLE  = 5'b00001,
        T_SEG1  = 5'b00010,
        T_CHECK = 5'b00100,
        T_SEG2  = 5'b01000,
        T_EMIT  = 5'b10000
    } t_top_state;

    t_top_state r_state, n_state;
    logic       r_closed;
    logic       r_have_prev;
    logic       r_last;
    logic       r_sat;
    t_sum       r_total;
    t_coord     r_first_x, r_first_y;
    t_coord     r_prev_x, r_prev_y;
    logic       r_out_valid;
    t_out_item  r_out_data;

    t_seg_req   seg_req;
    t_seg_rsp   seg_rsp;
    logic       in_take;
    logic       out_load;
    logic       close_start;
    logic [SUM_W:0] sum_ext;
    t_sum       acc_total;
    logic       acc_sat;

    assign o_in_ready  = (r_state == T_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == T_EMIT) && (!r_out_valid || i_out_ready);
    assign close_start = (r_state == T_CHECK) && r_last && r_closed;

    // segment requests: new vertex against previous, or closing against first
    always_comb begin
        seg_req.start = (in_take && r_have_prev) || close_start;
        if (r_state == T_CHECK) begin
            seg_req.mx = abs_diff(r_prev_x, r_first_x);
            seg_req.my = abs_diff(r_prev_y, r_first_y);
        end else begin
            seg_req.mx = abs_diff(i_in_data.x_coord, r_prev_x);
            seg_req.my = abs_diff(i_in_data.y_coord, r_prev_y);
        end
    end

    pla_seglen u_seglen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (seg_req),
        .o_rsp   (seg_rsp)
    );

    // saturating accumulate of a finished segment
    always_comb begin
        sum_ext   = {1'b0, r_total} + (SUM_W + 1)'(seg_rsp.len);
        acc_total = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        acc_sat   = r_sat | sum_ext[SUM_W];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (in_take) n_state = r_have_prev ? T_SEG1 : T_CHECK;
            end
            T_SEG1: begin
                if (seg_rsp.done) n_state = T_CHECK;
            end
            T_CHECK: begin
                if (!r_last)       n_state = T_IDLE;
                else if (r_closed) n_state = T_SEG2;
                else               n_state = T_EMIT;
            end
            T_SEG2: begin
                if (seg_rsp.done) n_state = T_EMIT;
            end
            T_EMIT: begin
                if (out_load) n_state = T_IDLE;
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    // control state, path flags and the running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_closed    <= 1'b0;
            r_have_prev <= 1'b0;
            r_sat       <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_closed <= i_cfg_data;
            if (in_take) r_have_prev <= 1'b1;
            if (seg_rsp.done && (r_state == T_SEG1 || r_state == T_SEG2)) begin
                r_total <= acc_total;
                r_sat   <= acc_sat;
            end
            if (out_load) begin
                r_have_prev <= 1'b0;
                r_sat       <= 1'b0;
                r_total     <= '0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // vertex registers and the output payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_prev_x <= i_in_data.x_coord;
            r_prev_y <= i_in_data.y_coord;
            r_last   <= i_in_data.last_point;
            if (!r_have_prev) begin
                r_first_x <= i_in_data.x_coord;
                r_first_y <= i_in_data.y_coord;
            end
        end
        if (out_load) begin
            r_out_data.total_length <= TOTAL_W'(r_total);
            r_out_data.overflowed   <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    `PLA_ASSERT_NOW(a_sat_pins_max, i_clk, i_rst_n, r_sat, r_total == SUM_MAX,
        "overflow flag set while total is below its maximum")
    `PLA_ASSERT_NOW(a_done_when_waiting, i_clk, i_rst_n, seg_rsp.done,
        r_state == T_SEG1 || r_state == T_SEG2, "segment finished with no request pending")
    `PLA_ASSERT_NOW(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state == T_EMIT), "result appeared without an emit step")
    `PLA_ASSERT_NEXT(a_clear_after_emit, i_clk, i_rst_n, out_load,
        !r_have_prev && r_total == '0 && !r_sat, "path state not cleared after emit")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pla_pkg::*;

    localparam int  HALF_PERIOD  = 6;
    localparam int  RESET_CYCLES = 7;
    localparam int  QUIET_LIMIT  = 3000;
    localparam int  HOLD_CYCLES  = 600;
    localparam int  SETTLE_WAIT  = 120;
    localparam int  BLOCK_POINTS = 208;
    localparam bit  OPEN_PATH    = 1'b0;
    localparam bit  CLOSED_PATH  = 1'b1;

    typedef struct {
        t_coord x;
        t_coord y;
        bit     last;
        bit     mode;
        bit     typed;
        t_sum   want_len;
    } t_vertex_row;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    // path tracker state
    t_coord path_first_x, path_first_y, path_prev_x, path_prev_y;
    t_sum   path_total;
    bit     path_open;
    bit     path_sat;
    bit     closed_flag;

    t_out_item   expected_totals[$];
    t_vertex_row vertex_table[$];

    int error_count;
    int vertex_count;
    int total_count;
    int mode_writes;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_request;
    int quiet_cycles;

    polyline_length_accumulator_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // floor of the square root, one result bit per pass
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned segment_length(input t_coord ax, input t_coord ay,
                                                       input t_coord bx, input t_coord by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return floor_root(longint'(dx * dx + dy * dy));
    endfunction

    // saturating add into the running total
    task automatic add_length(input longint unsigned seg);
        longint unsigned room;
        room = 64'(SUM_MAX) - 64'(path_total);
        if (seg > room) begin
            path_total = SUM_MAX;
            path_sat   = 1'b1;
        end else begin
            path_total = path_total + t_sum'(seg);
        end
    endtask

    // advance the path by one vertex, give the total on the last one
    task automatic trace_vertex(input t_in_item pt, output bit emits, output t_out_item res);
        emits = 1'b0;
        res   = '0;
        if (!path_open) begin
            path_first_x = pt.x_coord;
            path_first_y = pt.y_coord;
            path_open    = 1'b1;
        end else begin
            add_length(segment_length(path_prev_x, path_prev_y, pt.x_coord, pt.y_coord));
        end
        path_prev_x = pt.x_coord;
        path_prev_y = pt.y_coord;
        if (pt.last_point) begin
            if (closed_flag)
                add_length(segment_length(pt.x_coord, pt.y_coord, path_first_x, path_first_y));
            emits            = 1'b1;
            res.total_length = path_total;
            res.overflowed   = path_sat;
            path_first_x = '0;
            path_first_y = '0;
            path_prev_x  = '0;
            path_prev_y  = '0;
            path_total   = '0;
            path_open    = 1'b0;
            path_sat     = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // offer one vertex request, with random idle cycles ahead of it
    task automatic send_point(input t_in_item pt, input bit typed, input t_sum want_len);
        bit        emits;
        t_out_item res;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= pt;
        do @(posedge clk); while (!in_ready);
        vertex_count++;
        trace_vertex(pt, emits, res);
        if (emits) begin
            if (typed) begin
                res.total_length = want_len;
                res.overflowed   = 1'b0;
            end
            expected_totals.insert(expected_totals.size(), res);
        end
    endtask

    // drop valid, drain every total, then give the block time to go idle
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_totals.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_mode(input bit mode);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (!cfg_ready);
        closed_flag = mode;
        mode_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input int x, input int y, input bit last, input bit mode,
                           input bit typed, input int unsigned want_len);
        t_vertex_row r;
        r.x        = t_coord'(x);
        r.y        = t_coord'(y);
        r.last     = last;
        r.mode     = mode;
        r.typed    = typed;
        r.want_len = t_sum'(want_len);
        vertex_table.insert(vertex_table.size(), r);
    endtask

    // short hops from the previous vertex half the time, otherwise extremes and wild jumps
    function automatic t_coord pick_coord(input t_coord near);
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2, 3, 4: return t_coord'($urandom);
            default: return near + t_coord'($urandom_range(511) - 256);
        endcase
    endfunction

    task automatic send_random_path(inout int sent);
        int       n;
        t_in_item pt;
        t_coord   cx;
        t_coord   cy;
        cx = t_coord'($urandom);
        cy = t_coord'($urandom);
        case ($urandom_range(9))
            0:       n = 1;
            1:       n = $urandom_range(9, 20);
            default: n = $urandom_range(2, 8);
        endcase
        for (int k = 0; k < n; k++) begin
            cx            = pick_coord(cx);
            cy            = pick_coord(cy);
            pt.x_coord    = cx;
            pt.y_coord    = cy;
            pt.last_point = (k == n - 1);
            send_point(pt, 1'b0, '0);
            sent++;
        end
    endtask

    // result receiver, with random stalls and one long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_request > 0) begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // compare each accepted total with the oldest prediction
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_totals.size() == 0) begin
                report_mismatch("total with nothing pending", out_data.total_length, -1);
            end else begin
                want = expected_totals.pop_front();
                total_count++;
                if (out_data.total_length !== want.total_length)
                    report_mismatch("total_length", out_data.total_length, want.total_length);
                if (out_data.overflowed !== want.overflowed)
                    report_mismatch("overflowed", out_data.overflowed, want.overflowed);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // main sequence
    initial begin
        int sent;
        bit mode;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        error_count   = 0;
        vertex_count  = 0;
        total_count   = 0;
        mode_writes   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 0;
        quiet_cycles  = 0;
        closed_flag   = OPEN_PATH;
        path_first_x  = '0;
        path_first_y  = '0;
        path_prev_x   = '0;
        path_prev_y   = '0;
        path_total    = '0;
        path_open     = 1'b0;
        path_sat      = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // open paths: single vertices, a 3-4-5 hop, corner to corner, a null segment
        add_row(0, 0, 1, OPEN_PATH, 1, 0);
        add_row(32767, 32767, 1, OPEN_PATH, 1, 0);
        add_row(0, 0, 0, OPEN_PATH, 0, 0);
        add_row(3, 4, 1, OPEN_PATH, 1, 5);
        add_row(-32768, -32768, 0, OPEN_PATH, 0, 0);
        add_row(32767, 32767, 0, OPEN_PATH, 0, 0);
        add_row(-32768, 32767, 0, OPEN_PATH, 0, 0);
        add_row(32767, -32768, 1, OPEN_PATH, 0, 0);
        add_row(100, -200, 0, OPEN_PATH, 0, 0);
        add_row(100, -200, 1, OPEN_PATH, 1, 0);
        // closed paths: single vertex, right triangle, extreme diagonal and back, mixed
        add_row(-32768, 32767, 1, CLOSED_PATH, 1, 0);
        add_row(0, 0, 0, CLOSED_PATH, 0, 0);
        add_row(3, 0, 0, CLOSED_PATH, 0, 0);
        add_row(3, 4, 1, CLOSED_PATH, 1, 12);
        add_row(-32768, -32768, 0, CLOSED_PATH, 0, 0);
        add_row(32767, 32767, 1, CLOSED_PATH, 0, 0);
        add_row(-1, -1, 0, CLOSED_PATH, 0, 0);
        add_row(1, 1, 0, CLOSED_PATH, 0, 0);
        add_row(21845, -21846, 1, CLOSED_PATH, 0, 0);

        send_idle_pct = 20;
        recv_idle_pct = 20;
        write_mode(OPEN_PATH);
        foreach (vertex_table[i]) begin
            if (vertex_table[i].mode != closed_flag) begin
                settle_block();
                write_mode(vertex_table[i].mode);
            end
            send_point('{x_coord: vertex_table[i].x, y_coord: vertex_table[i].y,
                         last_point: vertex_table[i].last},
                       vertex_table[i].typed, vertex_table[i].want_len);
        end

        // random paths under three idle patterns, mode flipped halfway through each
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 26; recv_idle_pct = 50; end
                1: begin send_idle_pct = 50; recv_idle_pct = 26; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int half = 0; half < 2; half++) begin
                settle_block();
                mode = ((ph + half) % 2 == 1) ? CLOSED_PATH : OPEN_PATH;
                write_mode(mode);
                // hold results back long enough for the input side to back up
                if (ph == 2 && half == 0) stall_request = HOLD_CYCLES;
                sent = 0;
                while (sent < BLOCK_POINTS) send_random_path(sent);
            end
        end

        settle_block();
        foreach (expected_totals[i])
            report_mismatch("missing total", -1, expected_totals[i].total_length);

        $display("covered %0d vertices and %0d path totals over %0d mode writes",
                 vertex_count, total_count, mode_writes);
        $display("open and closed paths, coordinate extremes, a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
